FILE: hdl/srts_pkg.sv
// shared constants, command and status types for the track sequencer
package srts_pkg;

  localparam int MAX_TRACKS = 256;
  localparam int AW = $clog2(MAX_TRACKS);
  localparam int CW = AW + 1;

  localparam logic [1:0] OPC_NEXT = 2'd0;
  localparam logic [1:0] OPC_PREV = 2'd1;
  localparam logic [1:0] OPC_JUMP = 2'd2;
  localparam logic [1:0] OPC_NOP  = 2'd3;

  localparam logic [1:0] REG_COUNT   = 2'd0;
  localparam logic [1:0] REG_SHUFFLE = 2'd1;
  localparam logic [1:0] REG_REPEAT  = 2'd2;
  localparam logic [1:0] REG_SEED    = 2'd3;

  localparam logic [1:0] REP_NONE = 2'd0;
  localparam logic [1:0] REP_ONE  = 2'd1;
  localparam logic [1:0] REP_ALL  = 2'd2;

  localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_STOP, OP_SEQ, OP_JUMP, OP_SH_NEXT, OP_SH_PREV,
    OP_LOAD_CUR, OP_RD0, OP_INIT_K, OP_FILL, OP_SH_START, OP_DRAW, OP_MOD,
    OP_RD_I, OP_RD_J, OP_WR_I, OP_WR_J, OP_SET_VALID, OP_RD_K, OP_INC_K,
    OP_SET_CURSOR, OP_WR_K, OP_WR0_CUR, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic       build_req;
    logic       n_zero;
    logic       n_one;
    logic [1:0] opc;
    logic       jump_ok;
    logic       rep_none;
    logic       rep_one;
    logic       shuffle;
    logic       valid;
    logic       at_end;
    logic       at_start;
    logic       k_last;
    logic       i_one;
    logic       mod_last;
    logic       match;
  } dp_status_t;

endpackage

FILE: hdl/shuffle_repeat_track_sequencer_core.sv
// top level of the shuffle and repeat track sequencer
// usage:
//   s_axis carries step commands, one item per step; m_axis returns one
//   result item per command: the current entry and a stopped flag.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the count, shuffle, repeat and seed
//   registers; write them only while no command is in flight.
// sequential steps and jumps pass the dispatch and emit states after accept;
//   shuffle steps add a step state and, unless stopped at an end, a load.
// a permutation build walks a fill pass over the n entries, then n-1 swaps
//   (a draw from the lfsr, a 4-bit-per-cycle remainder unit and the order
//   table reads and writes), then, but for the rebuild on a wrap, a search
//   of the table to anchor the current entry.
// a jump with a valid permutation searches the order table, entry by
//   entry, to resync the cursor.
// one command is handled at a time; s_axis_tready is high only when idle.
// enabling shuffle with a nonempty list starts a build at once, during
//   which no command is taken.
// reset clears the registers: empty list, sequential order, no repeat,
//   seed 1, no current entry.
// when the receiver stalls the result holds in the output register; a
//   next command may be taken but its result waits for the slot.
module shuffle_repeat_track_sequencer_core import srts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] opcode, [9:2] jump_index, zero above
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [8:0] track_index, [9] stopped, zero above
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [9:0] result;

  srts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cfg_we_i    (cfg_we_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  srts_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_o      (result)
  );

  // result register sits in the datapath; pad up to whole bytes
  assign m_axis_tdata = {6'd0, result};

endmodule

FILE: hdl/srts_dp.sv
// datapath: registers, order table, lfsr and remainder unit
module srts_dp import srts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [15:0] in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output logic [9:0] out_o
);

  logic [CW-1:0] count_q;
  logic          shuf_q;
  logic [1:0]    rep_q;
  logic [31:0]   lfsr_q;
  logic [CW-1:0] cur_q;
  logic [AW-1:0] cursor_q, k_q, i_q, r_q, ti_q, tgt_q;
  logic          valid_q, stop_q;
  logic [1:0]    opc_q;
  logic [31:0]   dv_q;
  logic [2:0]    mcnt_q;
  logic [9:0]    out_q;

  logic [AW-1:0] mem [MAX_TRACKS];
  logic [AW-1:0] rdata_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr, mem_wdata;

  logic [AW-1:0] nm1, prev_pos;
  logic [CW-1:0] divisor, new_n;
  logic [CW-1:0] rem_w;
  logic [31:0]   lfsr_nx;
  logic          none;

  assign nm1      = count_q[AW-1:0] - AW'(1);
  assign prev_pos = (cursor_q == '0) ? nm1 : cursor_q - AW'(1);
  assign divisor  = {1'b0, i_q} + CW'(1);
  assign none     = (rep_q == REP_NONE);
  assign lfsr_nx  = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
  assign new_n    = (cfg_data_i[CW-1:0] > CW'(MAX_TRACKS)) ? CW'(MAX_TRACKS)
                                                            : cfg_data_i[CW-1:0];

  // four restoring remainder steps per cycle
  always_comb begin
    rem_w = {1'b0, r_q};
    for (int b = 0; b < 4; b++) begin
      rem_w = {rem_w[AW-1:0], dv_q[31-b]};
      if (rem_w >= divisor) rem_w = rem_w - divisor;
    end
  end

  always_comb begin
    mem_re = 1'b0; mem_raddr = '0;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;
    case (cmd_i.op)
      OP_SH_NEXT: begin mem_re = 1'b1; mem_raddr = cursor_q + AW'(1); end
      OP_SH_PREV: begin mem_re = 1'b1; mem_raddr = prev_pos; end
      OP_RD0:     begin mem_re = 1'b1; mem_raddr = '0; end
      OP_RD_I:    begin mem_re = 1'b1; mem_raddr = i_q; end
      OP_RD_J:    begin mem_re = 1'b1; mem_raddr = r_q; end
      OP_RD_K:    begin mem_re = 1'b1; mem_raddr = k_q; end
      OP_FILL:    begin mem_we = 1'b1; mem_waddr = k_q; mem_wdata = k_q; end
      OP_WR_I:    begin mem_we = 1'b1; mem_waddr = i_q; mem_wdata = rdata_q; end
      OP_WR_J:    begin mem_we = 1'b1; mem_waddr = r_q; mem_wdata = ti_q; end
      OP_WR_K:    begin mem_we = 1'b1; mem_waddr = k_q; mem_wdata = rdata_q; end
      OP_WR0_CUR: begin mem_we = 1'b1; mem_waddr = '0; mem_wdata = cur_q[AW-1:0]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin tgt_q <= in_data_i[9:2]; end
      OP_DRAW:   begin dv_q <= lfsr_nx; r_q <= '0; end
      OP_MOD:    begin dv_q <= dv_q << 4; r_q <= rem_w[AW-1:0]; end
      OP_RD_J:   ti_q <= rdata_q;
      OP_EMIT:   out_q <= {stop_q, cur_q};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; shuf_q <= 1'b0; rep_q <= REP_NONE; lfsr_q <= 32'd1;
      cur_q <= '1; cursor_q <= '0; valid_q <= 1'b0; k_q <= '0; i_q <= '0;
      mcnt_q <= '0; stop_q <= 1'b0; opc_q <= OPC_NEXT;
    end else begin
      case (cmd_i.op)
        OP_ACCEPT: begin opc_q <= in_data_i[1:0]; stop_q <= 1'b0; end
        OP_STOP:   stop_q <= 1'b1;
        OP_SEQ: begin
          if (opc_q == OPC_NEXT) begin
            if (cur_q[AW-1:0] == nm1) begin
              if (none) stop_q <= 1'b1;
              else cur_q <= '0;
            end else cur_q <= cur_q + CW'(1);
          end else begin
            if (cur_q == '0) begin
              if (none) stop_q <= 1'b1;
              else cur_q <= {1'b0, nm1};
            end else cur_q <= cur_q - CW'(1);
          end
        end
        OP_JUMP:       begin cur_q <= {1'b0, tgt_q}; k_q <= '0; end
        OP_SH_NEXT:    cursor_q <= cursor_q + AW'(1);
        OP_SH_PREV:    cursor_q <= prev_pos;
        OP_LOAD_CUR:   cur_q <= {1'b0, rdata_q};
        OP_INIT_K:     k_q <= '0;
        OP_FILL:       k_q <= k_q + AW'(1);
        OP_SH_START:   i_q <= nm1;
        OP_DRAW:       begin lfsr_q <= lfsr_nx; mcnt_q <= '0; end
        OP_MOD:        mcnt_q <= mcnt_q + 3'd1;
        OP_WR_J:       i_q <= i_q - AW'(1);
        OP_SET_VALID:  begin valid_q <= 1'b1; cursor_q <= '0; k_q <= '0; end
        OP_INC_K:      k_q <= k_q + AW'(1);
        OP_SET_CURSOR: cursor_q <= k_q;
        default: ;
      endcase
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_COUNT: begin
            count_q <= new_n; valid_q <= 1'b0; cursor_q <= '0;
            if (new_n == '0) cur_q <= '1;
            else if (cur_q[CW-1]) cur_q <= '0;
            else if (cur_q >= new_n) cur_q <= new_n - CW'(1);
          end
          REG_SHUFFLE: begin shuf_q <= cfg_data_i[0]; valid_q <= 1'b0; cursor_q <= '0; end
          REG_REPEAT:  rep_q <= cfg_data_i[1:0];
          REG_SEED:    lfsr_q <= (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    status_o.build_req = cfg_we_i && (cfg_idx_i == REG_SHUFFLE) && cfg_data_i[0] &&
                         (count_q != '0);
    status_o.n_zero   = (count_q == '0);
    status_o.n_one    = (count_q == CW'(1));
    status_o.opc      = opc_q;
    status_o.jump_ok  = ({1'b0, tgt_q} < count_q);
    status_o.rep_none = none;
    status_o.rep_one  = (rep_q == REP_ONE);
    status_o.shuffle  = shuf_q;
    status_o.valid    = valid_q;
    status_o.at_end   = (cursor_q == nm1);
    status_o.at_start = (cursor_q == '0);
    status_o.k_last   = (k_q == nm1);
    status_o.i_one    = (i_q == AW'(1));
    status_o.mod_last = (mcnt_q == 3'd7);
    status_o.match    = (rdata_q == cur_q[AW-1:0]);
  end

  assign out_o = out_q;

endmodule

FILE: hdl/srts_ctrl.sv
// controller: sequences steps, permutation builds and table searches
module srts_ctrl import srts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cfg_we_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SH_STEP, S_LOAD, S_WRAP, S_EMIT,
    S_B_INIT, S_B_FILL, S_B_START, S_B_DRAW, S_B_MOD, S_B_RDI, S_B_RDJ,
    S_B_WRI, S_B_WRJ, S_B_FINISH, S_S_RD, S_S_CMP, S_A_RD0, S_A_WRK, S_A_WR0
  } state_e;

  typedef enum logic [1:0] {RET_IDLE, RET_STEP, RET_WRAP} ret_e;

  state_e state_q, state_d, ret_state;
  ret_e   ret_q, ret_d;
  logic   anchor_q, anchor_d, oval_q, oval_d;

  always_comb begin
    case (ret_q)
      RET_STEP: ret_state = S_SH_STEP;
      RET_WRAP: ret_state = S_WRAP;
      default:  ret_state = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE) && !cfg_we_i;
  assign out_valid_o = oval_q;

  always_comb begin
    state_d = state_q; ret_d = ret_q; anchor_d = anchor_q;
    oval_d = oval_q && !out_ready_i;
    cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (status_i.build_req) begin
          anchor_d = 1'b1; ret_d = RET_IDLE; state_d = S_B_INIT;
        end else if (in_valid_i && !cfg_we_i) begin
          cmd_o.op = OP_ACCEPT; state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_EMIT;
        if (status_i.n_zero) cmd_o.op = OP_STOP;
        else if (status_i.opc == OPC_JUMP) begin
          if (status_i.jump_ok) begin
            cmd_o.op = OP_JUMP; anchor_d = 1'b0;
            if (status_i.valid) state_d = S_S_RD;
          end
        end else if ((status_i.opc == OPC_NEXT || status_i.opc == OPC_PREV) &&
                     !status_i.rep_one) begin
          if (!status_i.shuffle) cmd_o.op = OP_SEQ;
          else if (!status_i.valid) begin
            anchor_d = 1'b1; ret_d = RET_STEP; state_d = S_B_INIT;
          end else state_d = S_SH_STEP;
        end
      end
      S_SH_STEP: begin
        if (status_i.opc == OPC_NEXT) begin
          if (status_i.at_end) begin
            if (status_i.rep_none) begin cmd_o.op = OP_STOP; state_d = S_EMIT; end
            else begin anchor_d = 1'b0; ret_d = RET_WRAP; state_d = S_B_INIT; end
          end else begin cmd_o.op = OP_SH_NEXT; state_d = S_LOAD; end
        end else if (status_i.at_start && status_i.rep_none) begin
          cmd_o.op = OP_STOP; state_d = S_EMIT;
        end else begin cmd_o.op = OP_SH_PREV; state_d = S_LOAD; end
      end
      S_WRAP:  begin cmd_o.op = OP_RD0; state_d = S_LOAD; end
      S_LOAD:  begin cmd_o.op = OP_LOAD_CUR; state_d = S_EMIT; end
      S_EMIT: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.op = OP_EMIT; oval_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_B_INIT: begin cmd_o.op = OP_INIT_K; state_d = S_B_FILL; end
      S_B_FILL: begin
        cmd_o.op = OP_FILL;
        if (status_i.k_last) state_d = S_B_START;
      end
      S_B_START: begin
        cmd_o.op = OP_SH_START;
        state_d = status_i.n_one ? S_B_FINISH : S_B_DRAW;
      end
      S_B_DRAW: begin cmd_o.op = OP_DRAW; state_d = S_B_MOD; end
      S_B_MOD: begin
        cmd_o.op = OP_MOD;
        if (status_i.mod_last) state_d = S_B_RDI;
      end
      S_B_RDI: begin cmd_o.op = OP_RD_I; state_d = S_B_RDJ; end
      S_B_RDJ: begin cmd_o.op = OP_RD_J; state_d = S_B_WRI; end
      S_B_WRI: begin cmd_o.op = OP_WR_I; state_d = S_B_WRJ; end
      S_B_WRJ: begin
        cmd_o.op = OP_WR_J;
        state_d = status_i.i_one ? S_B_FINISH : S_B_DRAW;
      end
      S_B_FINISH: begin
        cmd_o.op = OP_SET_VALID;
        state_d = anchor_q ? S_S_RD : ret_state;
      end
      S_S_RD: begin cmd_o.op = OP_RD_K; state_d = S_S_CMP; end
      S_S_CMP: begin
        if (status_i.match) begin
          if (anchor_q) state_d = S_A_RD0;
          else begin cmd_o.op = OP_SET_CURSOR; state_d = S_EMIT; end
        end else begin cmd_o.op = OP_INC_K; state_d = S_S_RD; end
      end
      S_A_RD0: begin cmd_o.op = OP_RD0; state_d = S_A_WRK; end
      S_A_WRK: begin cmd_o.op = OP_WR_K; state_d = S_A_WR0; end
      S_A_WR0: begin cmd_o.op = OP_WR0_CUR; state_d = ret_state; end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= RET_IDLE; anchor_q <= 1'b0; oval_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; anchor_q <= anchor_d; oval_q <= oval_d;
    end
  end

endmodule

FILE: hdl/srts_checker.sv
// port-level checks for the track sequencer, bound to the top level
module srts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one command in flight: no accept straight after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command taken while busy");

  // no current entry only for an empty list, which always reports stopped
  a_none_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[8:0] == 9'h1FF) |-> m_axis_tdata[9])
    else $error("empty result without stopped");

endmodule

bind shuffle_repeat_track_sequencer_core srts_checker u_srts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: test/shuffle_repeat_track_sequencer_core_tb.sv
// self-checking testbench for the shuffle and repeat track sequencer core
module shuffle_repeat_track_sequencer_core_tb;
  import srts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [1:0] opcode, [9:2] jump_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [8:0] track_index, [9] stopped
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  shuffle_repeat_track_sequencer_core u_dut (.*);

  typedef struct packed {
    logic [8:0] track_index;
    logic       stopped;
  } step_result_t;

  // predictor copy of the sequencer state
  int unsigned  cnt_q, shuf_q, rep_q;
  int           cur_q;
  int unsigned  order_q [MAX_TRACKS];
  int unsigned  cursor_q;
  bit           ovalid_q;
  logic [31:0]  lfsr_q;

  step_result_t expected_q [$];
  int unsigned  n_fail, n_checked, idle_cycles, n_sent;
  bit           hold_off;

  function automatic logic [31:0] lfsr_draw();
    logic b;
    b = lfsr_q[0];
    lfsr_q = lfsr_q >> 1;
    if (b) lfsr_q = lfsr_q ^ LFSR_TAPS;
    return lfsr_q;
  endfunction

  function automatic void build_perm(bit anchor);
    int unsigned j, t;
    if (cnt_q == 0) return;
    for (int unsigned i = 0; i < cnt_q; i++) order_q[i] = i;
    for (int unsigned i = cnt_q - 1; i > 0; i--) begin
      j = lfsr_draw() % (i + 1);
      t = order_q[i]; order_q[i] = order_q[j]; order_q[j] = t;
    end
    cursor_q = 0;
    ovalid_q = 1;
    if (anchor && cur_q >= 0)
      for (int unsigned i = 0; i < cnt_q; i++)
        if (order_q[i] == cur_q) begin
          order_q[i] = order_q[0];
          order_q[0] = cur_q;
          break;
        end
  endfunction

  function automatic void predict_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_COUNT: begin
        cnt_q = val[8:0] > MAX_TRACKS ? MAX_TRACKS : val[8:0];
        if (cnt_q == 0) cur_q = -1;
        else if (cur_q < 0) cur_q = 0;
        else if (cur_q >= cnt_q) cur_q = cnt_q - 1;
        ovalid_q = 0; cursor_q = 0;
      end
      REG_SHUFFLE: begin
        shuf_q = val[0];
        ovalid_q = 0; cursor_q = 0;
        if (shuf_q && cnt_q > 0) build_perm(1);
      end
      REG_REPEAT: rep_q = val[1:0];
      default: lfsr_q = (val == 0) ? 32'd1 : val;
    endcase
  endfunction

  // works out the result of one step and advances the predictor
  function automatic step_result_t predict_step(logic [1:0] opc, logic [7:0] tgt);
    step_result_t r;
    bit stop, none;
    int c;
    stop = 0;
    none = (rep_q == REP_NONE);
    if (cnt_q == 0) stop = 1;
    else if (opc == OPC_JUMP) begin
      if (tgt < cnt_q) begin
        cur_q = tgt;
        if (ovalid_q)
          for (int unsigned i = 0; i < cnt_q; i++)
            if (order_q[i] == tgt) begin cursor_q = i; break; end
      end
    end else if (opc <= OPC_PREV && rep_q != REP_ONE) begin
      if (shuf_q && !ovalid_q) build_perm(1);
      if (shuf_q) begin
        if (opc == OPC_NEXT) begin
          if (cursor_q + 1 >= cnt_q) begin
            if (none) stop = 1;
            else begin
              build_perm(0);
              cur_q = order_q[0];
            end
          end else begin
            cursor_q++;
            cur_q = order_q[cursor_q];
          end
        end else if (cursor_q == 0) begin
          if (none) stop = 1;
          else begin cursor_q = cnt_q - 1; cur_q = order_q[cursor_q]; end
        end else begin
          cursor_q--;
          cur_q = order_q[cursor_q];
        end
      end else if (opc == OPC_NEXT) begin
        c = cur_q + 1;
        if (c >= int'(cnt_q)) begin
          if (none) begin c = cnt_q - 1; stop = 1; end
          else c = 0;
        end
        cur_q = c;
      end else begin
        c = cur_q - 1;
        if (c < 0) begin
          if (none) begin c = 0; stop = 1; end
          else c = cnt_q - 1;
        end
        cur_q = c;
      end
    end
    r.track_index = cur_q[8:0];
    r.stopped = stop;
    return r;
  endfunction

  // register write, only while idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    // wait out a permutation build still running
    while (!s_axis_tready) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    predict_reg(idx, val);
    // a shuffle enable starts a build; the input stalls until it ends
  endtask

  task automatic send_step(logic [1:0] opc, logic [7:0] tgt);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, tgt, opc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_step(opc, tgt));
    n_sent++;
  endtask

  // bursty sender: random gaps between bursts
  task automatic send_random(int unsigned n, int unsigned max_tgt);
    int unsigned burst;
    logic [1:0] opc;
    burst = 0;
    for (int unsigned k = 0; k < n; k++) begin
      if (burst == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
        burst = $urandom_range(1, 12);
      end
      burst--;
      opc = ($urandom_range(0, 19) == 0) ? OPC_NOP : 2'($urandom_range(0, 2));
      send_step(opc, ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                8'($urandom_range(0, max_tgt)));
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic test_empty_list();
    send_step(OPC_NEXT, 8'd0);
    send_step(OPC_PREV, 8'hFF);
    send_step(OPC_JUMP, 8'd0);
    send_step(OPC_NOP, 8'hAA);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic test_sequential_edges();
    write_reg(REG_COUNT, 32'd4);
    write_reg(REG_REPEAT, 32'(REP_NONE));
    send_step(OPC_PREV, 8'd0);
    for (int i = 0; i < 4; i++) send_step(OPC_NEXT, 8'd0);
    send_step(OPC_JUMP, 8'd9);
    send_step(OPC_JUMP, 8'd2);
    send_step(OPC_NOP, 8'h55);
    s_axis_tvalid <= 1'b0;
    write_reg(REG_REPEAT, 32'(REP_ALL));
    send_step(OPC_NEXT, 8'd0);
    send_step(OPC_NEXT, 8'd0);
    send_step(OPC_JUMP, 8'd0);
    send_step(OPC_PREV, 8'd0);
    s_axis_tvalid <= 1'b0;
    write_reg(REG_REPEAT, 32'(REP_ONE));
    send_step(OPC_NEXT, 8'd0);
    send_step(OPC_PREV, 8'd0);
    s_axis_tvalid <= 1'b0;
    // the unused repeat code behaves as repeat all
    write_reg(REG_REPEAT, 32'd3);
    send_step(OPC_NEXT, 8'd0);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic test_shuffle_walk();
    write_reg(REG_SEED, 32'd0);
    write_reg(REG_SHUFFLE, 32'd1);
    write_reg(REG_REPEAT, 32'(REP_NONE));
    for (int i = 0; i < 5; i++) send_step(OPC_NEXT, 8'd0);
    for (int i = 0; i < 5; i++) send_step(OPC_PREV, 8'd0);
    s_axis_tvalid <= 1'b0;
    write_reg(REG_REPEAT, 32'(REP_ALL));
    send_step(OPC_PREV, 8'd0);
    for (int i = 0; i < 6; i++) send_step(OPC_NEXT, 8'd0);
    send_step(OPC_JUMP, 8'd1);
    send_step(OPC_NEXT, 8'd0);
    s_axis_tvalid <= 1'b0;
  endtask

  // receiver stalls long so the output slot and the input both back up
  task automatic test_backpressure();
    write_reg(REG_SHUFFLE, 32'd0);
    hold_off = 1'b1;
    fork
      send_random(12, 7);
      begin repeat (300) @(posedge clk_i); hold_off = 1'b0; end
    join
  endtask

  task automatic test_random_phases();
    logic [31:0] cnt;
    for (int p = 0; p < 14; p++) begin
      write_reg(REG_SEED, $urandom);
      case (p % 7)
        0: cnt = 32'd1;
        1: cnt = 32'd256;
        2: cnt = 32'h1FF;   // saturates to the maximum
        3: cnt = 32'd2;
        default: cnt = $urandom_range(3, 20);
      endcase
      write_reg(REG_COUNT, cnt);
      write_reg(REG_REPEAT, $urandom_range(0, 3));
      write_reg(REG_SHUFFLE, $urandom_range(0, 1));
      send_random(38, (cnt > 255) ? 255 : cnt + 2);
    end
    write_reg(REG_COUNT, 32'd0);
    send_random(5, 255);
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (($urandom_range(0, 255) & 8'hC0) == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // result checker
  always @(posedge clk_i) begin
    step_result_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[8:0], m_axis_tdata[9]};
      if (expected_q.size() == 0) begin
        $error("result with no step outstanding: %h", m_axis_tdata);
        n_fail++;
      end else begin
        exp_r = expected_q.pop_front();
        n_checked++;
        if (got.track_index !== exp_r.track_index) begin
          $error("track_index expected %0d got %0d", $signed(exp_r.track_index),
                 $signed(got.track_index));
          n_fail++;
        end
        if (got.stopped !== exp_r.stopped) begin
          $error("stopped expected %0d got %0d", exp_r.stopped, got.stopped);
          n_fail++;
        end
        if (m_axis_tdata[15:10] !== '0) begin
          $error("pad bits expected 0 got %h", m_axis_tdata[15:10]);
          n_fail++;
        end
      end
    end
  end

  // watchdog: stops a run that sees no handshake or register write, with room for a full build over 256 entries
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 40000) begin
      $display("shuffle_repeat_track_sequencer_core verification failed");
      $finish;
    end
  end

  initial begin
    cnt_q = 0; shuf_q = 0; rep_q = 0; cur_q = -1;
    cursor_q = 0; ovalid_q = 0; lfsr_q = 32'd1;
    n_fail = 0; n_checked = 0; n_sent = 0; idle_cycles = 0; hold_off = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_sequential_edges();
    test_shuffle_walk();
    test_backpressure();
    test_random_phases();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d steps, %0d results checked, over empty, sequential", n_sent,
             n_checked);
    $display("and shuffled lists in every repeat mode, with long receiver stalls");
    if (n_fail == 0)
      $display("shuffle_repeat_track_sequencer_core verification clean");
    else
      $display("shuffle_repeat_track_sequencer_core verification failed");
    $finish;
  end

endmodule
